### rtl/region_record_sorter_unit_defines.svh
// assertion macros for the sorter rtl
`ifndef REGION_RECORD_SORTER_UNIT_DEFINES_SVH
`define REGION_RECORD_SORTER_UNIT_DEFINES_SVH

// checked outside reset
`define RRS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked in every cycle, reset included
`define RRS_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/rrs_pkg.sv
// types, constants and key compare for the region record sorter
package rrs_pkg;

  localparam int MAX_RECORDS = 64;
  localparam int CNT_W       = $clog2(MAX_RECORDS + 1);

  localparam int HEAD_W = 32;
  localparam int MID_W  = 32;
  localparam int TAIL_W = 8;
  localparam int POS_W  = 31;

  typedef struct packed {
    logic [HEAD_W-1:0] name_head;
    logic [MID_W-1:0]  name_mid;
    logic [TAIL_W-1:0] name_tail;
    logic [POS_W-1:0]  start_pos;
    logic [POS_W-1:0]  end_pos;
  } record_t;

  typedef struct packed {
    logic ins;
    logic shift;
  } cell_ctrl_t;

  typedef enum logic {
    ST_LOAD,
    ST_DRAIN
  } state_t;

  // true when a must sort strictly after b: name first, then start
  function automatic logic goes_after(record_t a, record_t b);
    logic [HEAD_W+MID_W+TAIL_W+POS_W-1:0] ka;
    logic [HEAD_W+MID_W+TAIL_W+POS_W-1:0] kb;
    ka = {a.name_head, a.name_mid, a.name_tail, a.start_pos};
    kb = {b.name_head, b.name_mid, b.name_tail, b.start_pos};
    return ka > kb;
  endfunction

endpackage

### rtl/rrs_load_if.sv
// channel carrying unsorted region records into the sorter
interface rrs_load_if;
  logic                       valid;
  logic                       ready;
  logic [rrs_pkg::HEAD_W-1:0] name_head;
  logic [rrs_pkg::MID_W-1:0]  name_mid;
  logic [rrs_pkg::TAIL_W-1:0] name_tail;
  logic [rrs_pkg::POS_W-1:0]  start_pos;
  logic [rrs_pkg::POS_W-1:0]  end_pos;
  logic                       last_in;

  modport source (output valid, name_head, name_mid, name_tail, start_pos, end_pos, last_in,
                  input ready);
  modport sink   (input valid, name_head, name_mid, name_tail, start_pos, end_pos, last_in,
                  output ready);
endinterface

### rtl/rrs_sorted_if.sv
// channel carrying sorted region records out of the sorter
interface rrs_sorted_if;
  logic                       valid;
  logic                       ready;
  logic [rrs_pkg::HEAD_W-1:0] out_name_head;
  logic [rrs_pkg::MID_W-1:0]  out_name_mid;
  logic [rrs_pkg::TAIL_W-1:0] out_name_tail;
  logic [rrs_pkg::POS_W-1:0]  out_start;
  logic [rrs_pkg::POS_W-1:0]  out_end;
  logic                       overflow;
  logic                       last_out;

  modport source (output valid, out_name_head, out_name_mid, out_name_tail, out_start,
                  out_end, overflow, last_out, input ready);
  modport sink   (input valid, out_name_head, out_name_mid, out_name_tail, out_start,
                  out_end, overflow, last_out, output ready);
endinterface

### rtl/rrs_cell.sv
// one insertion cell of the sorting chain
module rrs_cell (
  input  logic                clk,
  input  rrs_pkg::cell_ctrl_t ctrl,
  input  rrs_pkg::record_t    new_rec,
  input  logic                occupied,
  input  logic                prev_after,
  input  rrs_pkg::record_t    prev_rec,
  input  rrs_pkg::record_t    next_rec,
  output rrs_pkg::record_t    rec,
  output logic                after
);
  import rrs_pkg::*;

  record_t rec_next;

  // ties keep the stored word in front, so arrival order holds
  assign after = occupied && goes_after(rec, new_rec);

  always_comb begin
    rec_next = rec;
    if (ctrl.shift) begin
      rec_next = next_rec;
    end else if (ctrl.ins) begin
      if (occupied && !after) begin
        rec_next = rec;
      end else if (prev_after) begin
        rec_next = prev_rec;
      end else begin
        rec_next = new_rec;
      end
    end
  end

  always_ff @(posedge clk) begin
    rec <= rec_next;
  end

endmodule

### rtl/region_record_sorter_unit.sv
// region record sorter: stable sort by name then start
//
// load channel: one region record per word; the word with last_in set closes
// the set. up to MAX_RECORDS records are held in a chain of insertion cells,
// each new record finds its place in the cycle it is accepted, so
// loading runs at one word per cycle with no gaps.
// sorted channel: after the closing word the chain drains from its head, one
// sorted word per cycle while the receiver takes them; the first word goes
// through the state register and then the output register. load.ready is
// low during the drain, so loading and draining of a set do not overlap.
// records beyond capacity are dropped and every word of that set carries
// overflow; last_out marks the final word of the set.
// the output register holds a word while the receiver stalls and the chain
// stops shifting; the next set may start loading while the final word waits.
// reset (rst, synchronous) empties the chain and drops any pending word.
module region_record_sorter_unit (
  input logic   clk,
  input logic   rst,
  rrs_load_if.sink     load,
  rrs_sorted_if.source sorted
);
  import rrs_pkg::*;
  `include "region_record_sorter_unit_defines.svh"

  state_t            state;
  state_t            state_next;
  logic [CNT_W-1:0]  count;
  logic              dropped;
  logic              out_valid;
  record_t           out_rec;
  logic              out_over;
  logic              out_last;

  logic              accept;
  logic              full;
  logic              shift_en;
  cell_ctrl_t        ctrl;
  record_t           new_rec;
  record_t           cell_rec   [MAX_RECORDS];
  logic              cell_after [MAX_RECORDS];

  assign accept = load.valid && load.ready;
  assign full   = (count == CNT_W'(MAX_RECORDS));

  assign new_rec.name_head = load.name_head;
  assign new_rec.name_mid  = load.name_mid;
  assign new_rec.name_tail = load.name_tail;
  assign new_rec.start_pos = load.start_pos;
  assign new_rec.end_pos   = load.end_pos;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_LOAD: begin
        if (accept && load.last_in) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (shift_en && count == CNT_W'(1)) state_next = ST_LOAD;
      end
      default: state_next = ST_LOAD;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    load.ready = 1'b0;
    shift_en   = 1'b0;
    case (state)
      ST_LOAD:  load.ready = 1'b1;
      ST_DRAIN: shift_en = (count != '0) && (!out_valid || sorted.ready);
      default: begin
        load.ready = 1'b0;
        shift_en   = 1'b0;
      end
    endcase
  end

  assign ctrl.ins   = accept && !full;
  assign ctrl.shift = shift_en;

  for (genvar i = 0; i < MAX_RECORDS; i++) begin : g_cell
    logic    occ;
    logic    prev_after;
    record_t prev_rec;
    record_t next_rec;

    assign occ = (CNT_W'(i) < count);

    if (i == 0) begin : g_head
      assign prev_after = 1'b0;
      assign prev_rec   = new_rec;
    end else begin : g_body
      assign prev_after = cell_after[i-1];
      assign prev_rec   = cell_rec[i-1];
    end

    if (i == MAX_RECORDS - 1) begin : g_tail
      assign next_rec = cell_rec[i];
    end else begin : g_mid
      assign next_rec = cell_rec[i+1];
    end

    rrs_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .new_rec    (new_rec),
      .occupied   (occ),
      .prev_after (prev_after),
      .prev_rec   (prev_rec),
      .next_rec   (next_rec),
      .rec        (cell_rec[i]),
      .after      (cell_after[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_LOAD;
      count     <= '0;
      dropped   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (ctrl.ins) begin
        count <= count + CNT_W'(1);
      end else if (shift_en) begin
        count <= count - CNT_W'(1);
      end
      if (accept && full) begin
        dropped <= 1'b1;
      end else if (shift_en && count == CNT_W'(1)) begin
        dropped <= 1'b0;
      end
      if (shift_en) begin
        out_valid <= 1'b1;
      end else if (sorted.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (shift_en) begin
      out_rec  <= cell_rec[0];
      out_over <= dropped;
      out_last <= (count == CNT_W'(1));
    end
  end

  assign sorted.valid         = out_valid;
  assign sorted.out_name_head = out_rec.name_head;
  assign sorted.out_name_mid  = out_rec.name_mid;
  assign sorted.out_name_tail = out_rec.name_tail;
  assign sorted.out_start     = out_rec.start_pos;
  assign sorted.out_end       = out_rec.end_pos;
  assign sorted.overflow      = out_over;
  assign sorted.last_out      = out_last;

  `RRS_ASSERT(a_count_bound, count <= CNT_W'(MAX_RECORDS), "record count beyond capacity")
  `RRS_ASSERT(a_drop_flag, accept && full |=> dropped, "dropped record not flagged")
  `RRS_ASSERT(a_last_ends_drain, shift_en && count == CNT_W'(1) |=> state == ST_LOAD,
              "drain still running after final word")
  `RRS_ASSERT(a_drain_moves, state == ST_DRAIN && count != '0 && sorted.ready |=> sorted.valid,
              "drain stalled with receiver ready")
  `RRS_ASSERT_RST(a_reset_empty, rst |=> count == '0 && !sorted.valid,
                  "chain not empty after reset")

endmodule
